// ----- rtl/imh_pkg.sv -----
// Shared types and constants of the indexed min-heap block.
`timescale 1ns / 1ps
package imh_pkg;

    localparam int ID_W      = 10;
    localparam int KEY_W     = 31;
    localparam int ID_SPACE  = 1 << ID_W;
    localparam int TDATA_W   = 48;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

endpackage

// ----- rtl/imh_mem.sv -----
// Heap slot memory (two read ports, one write port) and the slot-of-id map memory.
`timescale 1ns / 1ps
module imh_mem #(
    parameter int NUM_IDS = 1024
) (
    input  logic                                     aclk,
    input  logic                                     heap_rd_en,
    input  logic [$clog2(NUM_IDS+1)-1:0]             heap_rd_addr_a,
    input  logic [$clog2(NUM_IDS+1)-1:0]             heap_rd_addr_b,
    output imh_pkg::entry_t                          heap_rd_a,
    output imh_pkg::entry_t                          heap_rd_b,
    input  logic                                     heap_wr_en,
    input  logic [$clog2(NUM_IDS+1)-1:0]             heap_wr_addr,
    input  imh_pkg::entry_t                          heap_wr_data,
    input  logic                                     slot_rd_en,
    input  logic [$clog2((NUM_IDS < 1024) ? NUM_IDS : 1024)-1:0] slot_rd_addr,
    output logic [$clog2(NUM_IDS+1)-1:0]             slot_rd_data,
    input  logic                                     slot_wr_en,
    input  logic [$clog2((NUM_IDS < 1024) ? NUM_IDS : 1024)-1:0] slot_wr_addr,
    input  logic [$clog2(NUM_IDS+1)-1:0]             slot_wr_data
);
    import imh_pkg::*;

    localparam int SW         = $clog2(NUM_IDS + 1);
    localparam int HEAP_DEPTH = 1 << SW;
    localparam int SLOT_DEPTH = (NUM_IDS < ID_SPACE) ? NUM_IDS : ID_SPACE;

    entry_t          heap_mem [HEAP_DEPTH];
    logic [SW-1:0]   slot_mem [SLOT_DEPTH];

    always_ff @(posedge aclk) begin
        if (heap_wr_en) begin
            heap_mem[heap_wr_addr] <= heap_wr_data;
        end
        if (heap_rd_en) begin
            heap_rd_a <= heap_mem[heap_rd_addr_a];
            heap_rd_b <= heap_mem[heap_rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_wr_en) begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_rd_en) begin
            slot_rd_data <= slot_mem[slot_rd_addr];
        end
    end

endmodule

// ----- rtl/indexed_min_heap_decrease_key_top.sv -----
// Top level of the indexed binary min-heap with insert, decrease-key and extract-min.
//
// Channel | Direction | Handshake          | Payload
// s_      | input     | s_tvalid/s_tready  | s_tdata: vertex_id, priority_req; s_tuser: kind
// m_      | output    | m_tvalid/m_tready  | m_tdata: min_id, min_priority; m_tuser: was_empty
//
// One transaction is worked on at a time. An insert reads the slot map, then sifts up,
// one parent compare per step; a decrease-key first reads the old key and stops unless
// the new key is lower. An extract reads the root and last entry, then sifts down, one
// child compare per step. Each compare costs one read of the heap memory.
// After reset the slot map memory is cleared, one entry a cycle, all min(NUM_IDS, 1024)
// entries, before s_tready rises. A stalled result waits in the output register; an
// insert may still be taken meanwhile, an extract holds in its last step.
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key_top #(
    parameter int NUM_IDS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [9:0] vertex_id, [40:10] priority_req, [47:41] zero
    input  logic        s_tuser,    // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [9:0] min_id, [40:10] min_priority, [47:41] zero
    output logic        m_tuser     // [0] was_empty
);
    import imh_pkg::*;

    localparam int SW         = $clog2(NUM_IDS + 1);
    localparam int SLOT_DEPTH = (NUM_IDS < ID_SPACE) ? NUM_IDS : ID_SPACE;
    localparam int SD_W       = $clog2(SLOT_DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_INS_SLOT, ST_INS_KEY, ST_UP_CMP, ST_UP_DONE,
        ST_EXT_RD, ST_DN_CMP, ST_DN_DONE, ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [SW-1:0]     pos_reg, pos_next;
    logic [SW-1:0]     cnt_reg, cnt_next;
    logic [SD_W-1:0]   clr_reg, clr_next;
    entry_t            ent_reg, ent_next;
    entry_t            res_reg, res_next;
    logic              res_empty_reg, res_empty_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [47:0]       m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic              h_rd_en;
    logic [SW-1:0]     h_rd_addr_a, h_rd_addr_b;
    entry_t            h_rd_a, h_rd_b;
    logic              h_wr_en;
    logic [SW-1:0]     h_wr_addr;
    entry_t            h_wr_data;
    logic              sl_rd_en;
    logic [SD_W-1:0]   sl_rd_addr;
    logic [SW-1:0]     sl_rd_data;
    logic              sl_wr_en;
    logic [SD_W-1:0]   sl_wr_addr;
    logic [SW-1:0]     sl_wr_data;

    logic [ID_W-1:0]   in_id;
    logic [KEY_W-1:0]  in_key;
    logic              id_ok;
    logic [SW-1:0]     new_pos;
    logic [SW:0]       left_idx, right_idx, pick_child_idx;
    logic              pick_right;
    entry_t            pick;
    logic [SW-1:0]     pick_slot;

    assign in_id  = s_tdata[ID_W-1:0];
    assign in_key = s_tdata[ID_W+KEY_W-1:ID_W];
    assign id_ok  = (NUM_IDS >= ID_SPACE) || (32'(in_id) < NUM_IDS);
    assign s_tready = (state_reg == ST_IDLE);

    assign new_pos   = cnt_reg + SW'(1);
    assign left_idx  = {pos_reg, 1'b0};
    assign right_idx = {pos_reg, 1'b1};
    // Ties go to the left child; the right child counts only if it exists.
    assign pick_right = (right_idx <= {1'b0, cnt_reg}) && (h_rd_b.key < h_rd_a.key);
    assign pick       = pick_right ? h_rd_b : h_rd_a;
    assign pick_slot  = pick_right ? right_idx[SW-1:0] : left_idx[SW-1:0];
    assign pick_child_idx = {pick_slot, 1'b0};

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        res_empty_next = res_empty_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        h_rd_en     = 1'b0;
        h_rd_addr_a = pos_reg;
        h_rd_addr_b = pos_reg;
        h_wr_en     = 1'b0;
        h_wr_addr   = pos_reg;
        h_wr_data   = ent_reg;
        sl_rd_en    = 1'b0;
        sl_rd_addr  = in_id[SD_W-1:0];
        sl_wr_en    = 1'b0;
        sl_wr_addr  = ent_reg.id[SD_W-1:0];
        sl_wr_data  = pos_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                sl_wr_en   = 1'b1;
                sl_wr_addr = clr_reg;
                sl_wr_data = '0;
                clr_next   = clr_reg + SD_W'(1);
                if (clr_reg == SD_W'(SLOT_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == KIND_INSERT) begin
                        if (id_ok) begin
                            ent_next   = '{key: in_key, id: in_id};
                            sl_rd_en   = 1'b1;
                            state_next = ST_INS_SLOT;
                        end
                    end else if (cnt_reg == '0) begin
                        res_next       = '0;
                        res_empty_next = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        h_rd_en        = 1'b1;
                        h_rd_addr_a    = SW'(1);
                        h_rd_addr_b    = cnt_reg;
                        res_empty_next = 1'b0;
                        state_next     = ST_EXT_RD;
                    end
                end
            end
            ST_INS_SLOT: begin
                if (sl_rd_data != '0) begin
                    pos_next    = sl_rd_data;
                    h_rd_en     = 1'b1;
                    h_rd_addr_a = sl_rd_data;
                    state_next  = ST_INS_KEY;
                end else if (cnt_reg == SW'(NUM_IDS)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = new_pos;
                    pos_next = new_pos;
                    if (new_pos > SW'(1)) begin
                        h_rd_en     = 1'b1;
                        h_rd_addr_a = new_pos >> 1;
                        state_next  = ST_UP_CMP;
                    end else begin
                        state_next = ST_UP_DONE;
                    end
                end
            end
            ST_INS_KEY: begin
                if (ent_reg.key < h_rd_a.key) begin
                    if (pos_reg > SW'(1)) begin
                        h_rd_en     = 1'b1;
                        h_rd_addr_a = pos_reg >> 1;
                        state_next  = ST_UP_CMP;
                    end else begin
                        state_next = ST_UP_DONE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_UP_CMP: begin
                // The moving entry stays in ent_reg; the parent drops into the hole.
                if (ent_reg.key < h_rd_a.key) begin
                    h_wr_en    = 1'b1;
                    h_wr_data  = h_rd_a;
                    sl_wr_en   = 1'b1;
                    sl_wr_addr = h_rd_a.id[SD_W-1:0];
                    pos_next   = pos_reg >> 1;
                    if ((pos_reg >> 1) > SW'(1)) begin
                        h_rd_en     = 1'b1;
                        h_rd_addr_a = pos_reg >> 2;
                    end else begin
                        state_next = ST_UP_DONE;
                    end
                end else begin
                    state_next = ST_UP_DONE;
                end
            end
            ST_UP_DONE: begin
                h_wr_en    = 1'b1;
                sl_wr_en   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EXT_RD: begin
                res_next   = h_rd_a;
                sl_wr_en   = 1'b1;
                sl_wr_addr = h_rd_a.id[SD_W-1:0];
                sl_wr_data = '0;
                if (cnt_reg > SW'(1)) begin
                    ent_next = h_rd_b;
                    cnt_next = cnt_reg - SW'(1);
                    pos_next = SW'(1);
                    if (cnt_reg > SW'(2)) begin
                        h_rd_en     = 1'b1;
                        h_rd_addr_a = SW'(2);
                        h_rd_addr_b = SW'(3);
                        state_next  = ST_DN_CMP;
                    end else begin
                        state_next = ST_DN_DONE;
                    end
                end else begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_DN_CMP: begin
                if (pick.key < ent_reg.key) begin
                    h_wr_en    = 1'b1;
                    h_wr_data  = pick;
                    sl_wr_en   = 1'b1;
                    sl_wr_addr = pick.id[SD_W-1:0];
                    pos_next   = pick_slot;
                    if (pick_child_idx <= {1'b0, cnt_reg}) begin
                        h_rd_en     = 1'b1;
                        h_rd_addr_a = pick_child_idx[SW-1:0];
                        h_rd_addr_b = pick_child_idx[SW-1:0] + SW'(1);
                    end else begin
                        state_next = ST_DN_DONE;
                    end
                end else begin
                    state_next = ST_DN_DONE;
                end
            end
            ST_DN_DONE: begin
                h_wr_en    = 1'b1;
                sl_wr_en   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(48 - ID_W - KEY_W){1'b0}}, res_reg.key, res_reg.id};
                    m_tuser_next  = res_empty_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pos_reg       <= pos_next;
        ent_reg       <= ent_next;
        res_reg       <= res_next;
        res_empty_reg <= res_empty_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    imh_mem #(
        .NUM_IDS(NUM_IDS)
    ) u_mem (
        .aclk          (aclk),
        .heap_rd_en    (h_rd_en),
        .heap_rd_addr_a(h_rd_addr_a),
        .heap_rd_addr_b(h_rd_addr_b),
        .heap_rd_a     (h_rd_a),
        .heap_rd_b     (h_rd_b),
        .heap_wr_en    (h_wr_en),
        .heap_wr_addr  (h_wr_addr),
        .heap_wr_data  (h_wr_data),
        .slot_rd_en    (sl_rd_en),
        .slot_rd_addr  (sl_rd_addr),
        .slot_rd_data  (sl_rd_data),
        .slot_wr_en    (sl_wr_en),
        .slot_wr_addr  (sl_wr_addr),
        .slot_wr_data  (sl_wr_data)
    );

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SW'(NUM_IDS))
        else $error("entry count exceeds capacity");

    a_extract_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_EXTRACT) |=> (state_reg != ST_IDLE))
        else $error("extract transaction produced no result step");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !h_wr_en)
        else $error("heap memory written while idle");

    a_pos_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UP_CMP || state_reg == ST_DN_CMP) |->
            (pos_reg != '0 && pos_reg <= cnt_reg))
        else $error("sift position outside the heap");

endmodule
